### hdl/exp_srch_pkg.sv
// shared constants and types for the exponential search block
package exp_srch_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int KEY_W       = 32;
    localparam int IDX_W       = ADDR_W + 2;

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic        [ADDR_W-1:0] addr_t;
    typedef logic        [LEN_W-1:0]  len_t;
    // signed probe index, wide enough for -1 and TABLE_DEPTH
    typedef logic signed [IDX_W-1:0]  idx_t;

endpackage

### hdl/exponential_search.sv
// exponential search over a table of signed 32-bit keys held in one synchronous ram
//
// A beat with operation = load writes key_value into table entry entry_index in the
// accept cycle and returns nothing; busy stays low, so a new beat may follow at once.
// A beat with operation = search looks for key_value in the first array_length entries
// (0 counts as 1, values above the table depth as the depth) and returns one beat:
// done is high for exactly one cycle with found valid beside it. The receiver cannot
// stall, so the result must be captured in that cycle. One table read is made per
// probe and the ram port is the limit: a search reads entry 0, then makes the doubling
// probes and a setup step, then the binary-search probes, with a step to open each
// half. busy is high while the search runs. array_length is written through cfg_we
// and cfg_data; the user must write it only while no search is running, as the block
// itself does not enforce this.
module exponential_search (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       operation,
    input  exp_srch_pkg::addr_t        entry_index,
    input  exp_srch_pkg::key_t         key_value,
    input  logic                       cfg_we,
    input  exp_srch_pkg::len_t         cfg_data,
    output logic                       done,
    output logic                       found
);
    import exp_srch_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ENT0   = 3'd1;
    localparam logic [2:0] S_DBL    = 3'd2;
    localparam logic [2:0] S_SETUP  = 3'd3;
    localparam logic [2:0] S_HISSUE = 3'd4;
    localparam logic [2:0] S_HCHK   = 3'd5;

    key_t        key_table_mem [TABLE_DEPTH];
    key_t        mem_q;
    addr_t       rd_addr;
    logic        mem_we;

    logic [2:0]  state_reg, state_next;
    key_t        key_reg, key_next;
    len_t        len_reg, len_next;
    len_t        cfg_len_reg;
    len_t        bound_reg, bound_next;
    idx_t        lo_reg, lo_next;
    idx_t        hi_reg, hi_next;
    idx_t        lo2_reg, lo2_next;
    idx_t        hi2_reg, hi2_next;
    idx_t        mid_reg, mid_next;
    logic        phase_reg, phase_next;
    logic        hit_reg, hit_next;
    logic        done_reg, done_next;
    logic        found_reg, found_next;

    logic        accept;
    len_t        len_clamp;
    len_t        dbl_v;
    len_t        len_m1;
    len_t        top_len;
    idx_t        base_v, top_v, half_v;
    idx_t        lo_v, hi_v, mid_v;
    logic        hit_v;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign found  = found_reg;
    assign accept = start && !busy;
    assign mem_we = accept && (operation == OP_LOAD);

    // table ram, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_table_mem[entry_index] <= key_value;
        end
        mem_q <= key_table_mem[rd_addr];
    end

    // length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len_reg <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            cfg_len_reg <= cfg_data;
        end
    end

    // clamp length into 1..depth
    always_comb
    begin
        if (cfg_len_reg == '0)
        begin
            len_clamp = LEN_W'(1);
        end
        else if (cfg_len_reg > LEN_W'(TABLE_DEPTH))
        begin
            len_clamp = LEN_W'(TABLE_DEPTH);
        end
        else
        begin
            len_clamp = cfg_len_reg;
        end
    end

    // range split after the doubling phase
    always_comb
    begin
        len_m1  = len_reg - LEN_W'(1);
        top_len = (bound_reg < len_m1) ? bound_reg : len_m1;
        base_v  = idx_t'({2'b00, bound_reg[LEN_W-1:1]});
        top_v   = idx_t'({1'b0, top_len});
        half_v  = (top_v - base_v + idx_t'(1)) >>> 1;
        dbl_v   = {bound_reg[LEN_W-2:0], 1'b0};
    end

    // search sequencer
    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        len_next   = len_reg;
        bound_next = bound_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        lo2_next   = lo2_reg;
        hi2_next   = hi2_reg;
        mid_next   = mid_reg;
        phase_next = phase_reg;
        hit_next   = hit_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        rd_addr    = '0;
        lo_v       = lo_reg;
        hi_v       = hi_reg;
        mid_v      = lo_reg + ((hi_reg - lo_reg) >>> 1);
        hit_v      = hit_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (operation == OP_SEARCH))
                begin
                    key_next   = key_value;
                    len_next   = len_clamp;
                    hit_next   = 1'b0;
                    rd_addr    = '0;
                    state_next = S_ENT0;
                end
            end
            S_ENT0:
            begin
                hit_next   = (mem_q == key_reg);
                bound_next = LEN_W'(1);
                if (len_reg > LEN_W'(1))
                begin
                    rd_addr    = ADDR_W'(1);
                    state_next = S_DBL;
                end
                else
                begin
                    state_next = S_SETUP;
                end
            end
            S_DBL:
            begin
                if (mem_q <= key_reg)
                begin
                    bound_next = dbl_v;
                    if (dbl_v < len_reg)
                    begin
                        rd_addr = dbl_v[ADDR_W-1:0];
                    end
                    else
                    begin
                        state_next = S_SETUP;
                    end
                end
                else
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                lo_next    = base_v;
                hi_next    = base_v + half_v - idx_t'(1);
                lo2_next   = base_v + half_v;
                hi2_next   = top_v;
                phase_next = 1'b0;
                state_next = S_HISSUE;
            end
            S_HISSUE:
            begin
                if (lo_reg <= hi_reg)
                begin
                    rd_addr    = mid_v[ADDR_W-1:0];
                    mid_next   = mid_v;
                    state_next = S_HCHK;
                end
                else if (!phase_reg)
                begin
                    lo_next    = lo2_reg;
                    hi_next    = hi2_reg;
                    phase_next = 1'b1;
                end
                else
                begin
                    done_next  = 1'b1;
                    found_next = hit_reg;
                    state_next = S_IDLE;
                end
            end
            S_HCHK:
            begin
                // equal entries narrow the high bound like larger ones
                if (mem_q == key_reg)
                begin
                    hit_v = 1'b1;
                end
                if (mem_q < key_reg)
                begin
                    lo_v = mid_reg + idx_t'(1);
                end
                else
                begin
                    hi_v = mid_reg - idx_t'(1);
                end
                mid_v    = lo_v + ((hi_v - lo_v) >>> 1);
                hit_next = hit_v;
                lo_next  = lo_v;
                hi_next  = hi_v;
                if (lo_v <= hi_v)
                begin
                    rd_addr  = mid_v[ADDR_W-1:0];
                    mid_next = mid_v;
                end
                else if (!phase_reg)
                begin
                    lo_next    = lo2_reg;
                    hi_next    = hi2_reg;
                    phase_next = 1'b1;
                    state_next = S_HISSUE;
                end
                else
                begin
                    done_next  = 1'b1;
                    found_next = hit_v;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        len_reg   <= len_next;
        bound_reg <= bound_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        lo2_reg   <= lo2_next;
        hi2_reg   <= hi2_next;
        mid_reg   <= mid_next;
        phase_reg <= phase_next;
        hit_reg   <= hit_next;
        found_reg <= found_next;
    end

    // result beat only ever follows the end of a search
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_SEARCH) |=> busy)
        else $error("search beat did not start the sequencer");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_LOAD) |=> (!done && !busy))
        else $error("load beat produced a result or stalled");

    a_dbl_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DBL) |-> (bound_reg < len_reg))
        else $error("doubling probe beyond table length");

    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HCHK) |-> (mid_reg >= idx_t'(0) && mid_reg < idx_t'(len_reg)))
        else $error("binary probe outside table");

endmodule
